/* hdl/tqbc_pkg.sv */
// ----------------------------------------------------------------------------
// tqbc_pkg
// Shared types and codes for the two-queue block cache policy.
// ----------------------------------------------------------------------------
`default_nettype none

package tqbc_pkg;

   localparam int unsigned KIND_W   = 2;
   localparam int unsigned ID_W     = 32;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned SLOT_W   = 5;
   localparam int unsigned LIMIT_W  = 5;

   localparam logic [KIND_W-1:0] KIND_GET_READ  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_GET_WRITE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RET_READ  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_RET_WRITE = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_CACHED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_CONFLICT   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NO_ROOM    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_HELD   = 3'd4;

   localparam logic [0:0] CSR_FIFO_LIMIT = 1'd0;
   localparam logic [0:0] CSR_LRU_LIMIT  = 1'd1;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

endpackage : tqbc_pkg

`default_nettype wire

/* hdl/two_queue_block_cache_policy.sv */
// ----------------------------------------------------------------------------
// two_queue_block_cache_policy
// Two-queue (probation FIFO plus LRU) replacement policy with holder counts.
// ----------------------------------------------------------------------------
// A request is taken only when the block is idle and the result register is
// empty. The id of every entry sits in a one-port synchronous memory that a
// sequencer sweeps once per request for lookup. When the target queue is
// full it walks the entries again for the victim search, and on a miss it
// searches for a free slot, one entry per cycle; the age update is applied
// to all entries at once. The result is registered when the sequence ends,
// and the next request can be taken the cycle after the result is accepted.
`default_nettype none

module two_queue_block_cache_policy #(
   parameter int unsigned QUEUE_DEPTH = 16,
   parameter int unsigned MAX_READERS = 255
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [tqbc_pkg::KIND_W-1:0]    req_kind,
   input  wire logic [tqbc_pkg::ID_W-1:0]      req_block_id,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [tqbc_pkg::STATUS_W-1:0]       rsp_status,
   output logic                                rsp_hit,
   output logic [tqbc_pkg::SLOT_W-1:0]         rsp_slot,
   output logic                                rsp_fetch,
   output logic                                rsp_writeback,
   output logic [tqbc_pkg::ID_W-1:0]           rsp_victim_id,
   input  wire logic                           csr_write_enable,
   input  wire logic                           csr_index,
   input  wire logic [tqbc_pkg::LIMIT_W-1:0]   csr_write_data
);

   localparam int unsigned ENTRIES = 2 * QUEUE_DEPTH;
   localparam int unsigned IDX_W   = $clog2(ENTRIES);
   localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
   localparam int unsigned AGE_W   = $clog2(QUEUE_DEPTH);
   localparam int unsigned QC_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned RD_W    = $clog2(MAX_READERS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_LOOK, S_DECIDE, S_VSCAN, S_EVICT, S_EVRD, S_MOVE,
      S_FREE, S_LINK, S_HOLD, S_DONE
   } state_type;

   // id memory
   logic [tqbc_pkg::ID_W-1:0] id_mem [ENTRIES];
   logic [tqbc_pkg::ID_W-1:0] id_rd_ff;
   logic [IDX_W-1:0]          mem_addr;
   logic                      mem_we;

   // per-entry flags and counters (each read at its own index by the sequencer)
   logic [ENTRIES-1:0] valid_ff, in_lru_ff, writer_ff, dirty_ff;
   logic [AGE_W-1:0]   age_ff     [ENTRIES];
   logic [RD_W-1:0]    readers_ff [ENTRIES];
   logic [QC_W-1:0]    qcount_ff  [2];

   logic [tqbc_pkg::LIMIT_W-1:0] fifo_limit_ff, lru_limit_ff;

   state_type                 state_ff;
   logic [tqbc_pkg::KIND_W-1:0] kind_ff;
   logic [tqbc_pkg::ID_W-1:0]   kind_id_ff;
   logic [CNT_W-1:0]          scan_ff;
   logic [IDX_W-1:0]          rd_ptr_ff;   // entry whose id arrives this cycle
   logic                      rd_vld_ff;
   logic                      found_ff;
   logic [IDX_W-1:0]          slot_ff;
   logic                      queue_ff;    // queue to make room in / link to
   logic                      vfound_ff;
   logic [IDX_W-1:0]          victim_ff;
   logic                      miss_ff;     // inserting a new block
   logic                      wb_ff;
   logic [tqbc_pkg::ID_W-1:0] vid_ff;
   logic [tqbc_pkg::STATUS_W-1:0] status_ff;
   logic                      fetch_ff;
   logic                      hit_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         id_mem[mem_addr] <= kind_id_ff;
      end
      id_rd_ff <= id_mem[mem_addr];
   end

   logic [IDX_W-1:0] scan_idx;
   assign scan_idx = scan_ff[IDX_W-1:0];

   // effective limit of the selected queue
   logic [tqbc_pkg::LIMIT_W-1:0] lim_raw;
   logic [QC_W-1:0]              lim_eff;
   always_comb begin
      lim_raw = queue_ff ? lru_limit_ff : fifo_limit_ff;
      if (lim_raw == '0) begin
         lim_eff = QC_W'(1);
      end else if (32'(lim_raw) > QUEUE_DEPTH) begin
         lim_eff = QC_W'(QUEUE_DEPTH);
      end else begin
         lim_eff = QC_W'(lim_raw);
      end
   end

   always_comb begin
      mem_we   = (state_ff == S_LINK) && miss_ff;
      mem_addr = scan_idx;
      if (state_ff == S_EVICT || state_ff == S_LINK) begin
         mem_addr = (state_ff == S_EVICT) ? victim_ff : slot_ff;
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid     <= 1'b0;
         valid_ff      <= '0;
         in_lru_ff     <= '0;
         writer_ff     <= '0;
         dirty_ff      <= '0;
         qcount_ff[0]  <= '0;
         qcount_ff[1]  <= '0;
         fifo_limit_ff <= tqbc_pkg::LIMIT_RESET;
         lru_limit_ff  <= tqbc_pkg::LIMIT_RESET;
         for (int e = 0; e < ENTRIES; e++) begin
            age_ff[e]     <= '0;
            readers_ff[e] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            if (csr_index == tqbc_pkg::CSR_FIFO_LIMIT) begin
               fifo_limit_ff <= csr_write_data;
            end else begin
               lru_limit_ff <= csr_write_data;
            end
         end
         if (rsp_valid && rsp_ready) begin
            rsp_valid <= 1'b0;
         end
         rd_ptr_ff <= scan_idx;
         rd_vld_ff <= (state_ff == S_LOOK) && (scan_ff < CNT_W'(ENTRIES));
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  kind_ff    <= req_kind;
                  kind_id_ff <= req_block_id;
                  scan_ff    <= '0;
                  found_ff   <= 1'b0;
                  wb_ff      <= 1'b0;
                  vid_ff     <= '0;
                  status_ff  <= tqbc_pkg::ST_OK;
                  fetch_ff   <= 1'b0;
                  miss_ff    <= 1'b0;
                  state_ff   <= S_LOOK;
               end
            end
            S_LOOK: begin
               // issue reads; compare the previous read, first match wins
               if (scan_ff < CNT_W'(ENTRIES)) begin
                  scan_ff <= scan_ff + 1'b1;
               end
               if (rd_vld_ff && !found_ff && valid_ff[rd_ptr_ff]
                   && id_rd_ff == kind_id_ff) begin
                  found_ff <= 1'b1;
                  slot_ff  <= rd_ptr_ff;
               end
               if (!rd_vld_ff && scan_ff == CNT_W'(ENTRIES)) begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               hit_ff <= found_ff;
               if (found_ff) begin
                  queue_ff <= 1'b1;
                  state_ff <= in_lru_ff[slot_ff] ? S_MOVE : S_VSCAN;
               end else if (kind_ff == tqbc_pkg::KIND_RET_READ
                            || kind_ff == tqbc_pkg::KIND_RET_WRITE) begin
                  status_ff <= tqbc_pkg::ST_NOT_CACHED;
                  state_ff  <= S_DONE;
               end else begin
                  queue_ff <= 1'b0;
                  miss_ff  <= 1'b1;
                  state_ff <= S_VSCAN;
               end
               scan_ff   <= '0;
               vfound_ff <= 1'b0;
            end
            S_VSCAN: begin
               if (qcount_ff[queue_ff] < lim_eff) begin
                  state_ff <= miss_ff ? S_FREE : S_MOVE;
                  scan_ff  <= '0;
               end else if (scan_ff == CNT_W'(ENTRIES)) begin
                  if (vfound_ff) begin
                     state_ff <= S_EVICT;
                  end else begin
                     status_ff <= tqbc_pkg::ST_NO_ROOM;
                     state_ff  <= S_DONE;
                  end
               end else begin
                  if (valid_ff[scan_idx] && in_lru_ff[scan_idx] == queue_ff
                      && readers_ff[scan_idx] == '0 && !writer_ff[scan_idx]
                      && (!vfound_ff || age_ff[scan_idx] > age_ff[victim_ff])) begin
                     vfound_ff <= 1'b1;
                     victim_ff <= scan_idx;
                  end
                  scan_ff <= scan_ff + 1'b1;
               end
            end
            S_EVICT: begin
               state_ff <= S_EVRD;
            end
            S_EVRD: begin
               if (dirty_ff[victim_ff]) begin
                  wb_ff  <= 1'b1;
                  vid_ff <= id_rd_ff;
               end
               for (int e = 0; e < ENTRIES; e++) begin
                  if (valid_ff[e] && IDX_W'(e) != victim_ff
                      && in_lru_ff[e] == queue_ff && age_ff[e] > age_ff[victim_ff]) begin
                     age_ff[e] <= age_ff[e] - 1'b1;
                  end
               end
               if (qcount_ff[queue_ff] != '0) begin
                  qcount_ff[queue_ff] <= qcount_ff[queue_ff] - 1'b1;
               end
               valid_ff[victim_ff]   <= 1'b0;
               in_lru_ff[victim_ff]  <= 1'b0;
               age_ff[victim_ff]     <= '0;
               readers_ff[victim_ff] <= '0;
               writer_ff[victim_ff]  <= 1'b0;
               dirty_ff[victim_ff]   <= 1'b0;
               scan_ff  <= '0;
               state_ff <= miss_ff ? S_FREE : S_MOVE;
            end
            S_MOVE: begin
               // unlink from its queue and link at the LRU head
               for (int e = 0; e < ENTRIES; e++) begin
                  if (valid_ff[e] && IDX_W'(e) != slot_ff) begin
                     if (in_lru_ff[e] == in_lru_ff[slot_ff]
                         && age_ff[e] > age_ff[slot_ff]) begin
                        if (in_lru_ff[e]) begin
                           age_ff[e] <= age_ff[e];
                        end else begin
                           age_ff[e] <= age_ff[e] - 1'b1;
                        end
                     end
                     if (in_lru_ff[e]) begin
                        if (!(in_lru_ff[slot_ff] && age_ff[e] > age_ff[slot_ff])) begin
                           age_ff[e] <= age_ff[e] + 1'b1;
                        end
                     end
                  end
               end
               if (!in_lru_ff[slot_ff]) begin
                  if (qcount_ff[0] != '0) begin
                     qcount_ff[0] <= qcount_ff[0] - 1'b1;
                  end
                  qcount_ff[1] <= qcount_ff[1] + 1'b1;
               end
               in_lru_ff[slot_ff] <= 1'b1;
               age_ff[slot_ff]    <= '0;
               state_ff <= S_HOLD;
            end
            S_FREE: begin
               if (scan_ff == CNT_W'(ENTRIES)) begin
                  status_ff <= tqbc_pkg::ST_NO_ROOM;
                  state_ff  <= S_DONE;
               end else if (!valid_ff[scan_idx]) begin
                  slot_ff  <= scan_idx;
                  found_ff <= 1'b1;
                  state_ff <= S_LINK;
               end else begin
                  scan_ff <= scan_ff + 1'b1;
               end
            end
            S_LINK: begin
               for (int e = 0; e < ENTRIES; e++) begin
                  if (valid_ff[e] && !in_lru_ff[e]) begin
                     age_ff[e] <= age_ff[e] + 1'b1;
                  end
               end
               valid_ff[slot_ff]   <= 1'b1;
               in_lru_ff[slot_ff]  <= 1'b0;
               age_ff[slot_ff]     <= '0;
               readers_ff[slot_ff] <= '0;
               writer_ff[slot_ff]  <= 1'b0;
               dirty_ff[slot_ff]   <= 1'b0;
               qcount_ff[0]        <= qcount_ff[0] + 1'b1;
               fetch_ff            <= 1'b1;
               state_ff            <= S_HOLD;
            end
            S_HOLD: begin
               unique case (kind_ff)
                  tqbc_pkg::KIND_GET_READ: begin
                     if (writer_ff[slot_ff]
                         || 32'(readers_ff[slot_ff]) >= MAX_READERS) begin
                        status_ff <= tqbc_pkg::ST_CONFLICT;
                     end else begin
                        readers_ff[slot_ff] <= readers_ff[slot_ff] + 1'b1;
                     end
                  end
                  tqbc_pkg::KIND_GET_WRITE: begin
                     if (writer_ff[slot_ff] || readers_ff[slot_ff] != '0) begin
                        status_ff <= tqbc_pkg::ST_CONFLICT;
                     end else begin
                        writer_ff[slot_ff] <= 1'b1;
                        dirty_ff[slot_ff]  <= 1'b1;
                     end
                  end
                  tqbc_pkg::KIND_RET_READ: begin
                     if (readers_ff[slot_ff] == '0) begin
                        status_ff <= tqbc_pkg::ST_NOT_HELD;
                     end else begin
                        readers_ff[slot_ff] <= readers_ff[slot_ff] - 1'b1;
                     end
                  end
                  default: begin
                     if (!writer_ff[slot_ff]) begin
                        status_ff <= tqbc_pkg::ST_NOT_HELD;
                     end else begin
                        writer_ff[slot_ff] <= 1'b0;
                     end
                  end
               endcase
               state_ff <= S_DONE;
            end
            S_DONE: begin
               rsp_valid     <= 1'b1;
               rsp_status    <= status_ff;
               rsp_hit       <= hit_ff;
               rsp_slot      <= found_ff ? tqbc_pkg::SLOT_W'(slot_ff) : '0;
               rsp_fetch     <= fetch_ff;
               rsp_writeback <= wb_ff;
               rsp_victim_id <= wb_ff ? vid_ff : '0;
               state_ff      <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule : two_queue_block_cache_policy

`default_nettype wire
